FILE: rtl/ebb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ebb_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUAT_W          = 32;
  localparam int QUAT_FRAC       = 30;
  localparam int ROT_LAT         = 2;
  localparam int SCL_LAT         = 3;
  localparam int CORNER_LAT      = 1;

  // stage control handed down the pipe
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/ellipsoid_bounding_box_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Axis-aligned bounding box of an oriented ellipsoid. Each input transfer
// carries a centre, a unit orientation quaternion (Q2.30) and three
// semi-axes; the result transfer carries the lower and upper box corners,
// saturated to the signed coordinate range. One ellipsoid is taken every
// clock cycle while the output register is empty or being read: the
// rotation stage registers the quaternion products, then the matrix
// magnitudes; the scale stage registers scaled entries, their squares and
// the row sums; the square-root pipelines follow; a last register holds
// the corners. The pipe moves as one, so an out_tready stall holds all items.
module ellipsoid_bounding_box_unit
  import ebb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // centre_x, centre_y, centre_z, quat_w, quat_x, quat_y, quat_z,
  // semi_axis_a, semi_axis_b, semi_axis_c, zero fill
  input  wire  [((6*COORD_WIDTH+125+7)/8)*8-1:0] in_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     out_tdata
);
  localparam int CW     = COORD_WIDTH;
  localparam int SW     = CW - 1;
  localparam int OUT_W  = ((6*CW+7)/8)*8;
  localparam int Q0     = 3*CW;                 // first quaternion bit
  localparam int S0     = Q0 + 4*QUAT_W;        // first semi-axis bit
  localparam int C_DLY  = ROT_LAT + SCL_LAT + CW;

  pipe_ctl_t ctl_in;
  pipe_ctl_t ctl_scl;
  pipe_ctl_t ctl_sqrt;
  pipe_ctl_t ctl_cnr;

  logic                     en;
  logic                     rot_vld;
  logic [8:0][QUAT_FRAC:0]  rabs;
  logic                     scl_vld;
  logic [2:0][2*CW-1:0]     sumsq;
  logic [2:0]               sqrt_vld;
  logic [2:0][CW-1:0]       delta;
  logic                     cnr_vld;
  logic [5:0][CW-1:0]       corners;

  // semi-axes wait for the matrix; centre waits for the half-extents
  logic [ROT_LAT-1:0][2:0][SW-1:0] semi_dly_r;
  logic [C_DLY-1:0][2:0][CW-1:0]   ctr_dly_r;
  logic [2:0][SW-1:0]              semi_in;
  logic [2:0][CW-1:0]              ctr_in;

  // global advance: output slot free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr_in[i]  = in_tdata[i*CW +: CW];
      semi_in[i] = in_tdata[S0 + i*SW +: SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      semi_dly_r[0] <= semi_in;
      for (int k = 1; k < ROT_LAT; k++) semi_dly_r[k] <= semi_dly_r[k-1];
      ctr_dly_r[0] <= ctr_in;
      for (int k = 1; k < C_DLY; k++) ctr_dly_r[k] <= ctr_dly_r[k-1];
    end
  end

  assign ctl_in   = '{en: en, vld: in_tvalid};
  assign ctl_scl  = '{en: en, vld: rot_vld};
  assign ctl_sqrt = '{en: en, vld: scl_vld};
  assign ctl_cnr  = '{en: en, vld: sqrt_vld[0]};

  ebb_rot u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_in),
    .quat_w  (in_tdata[Q0 +: QUAT_W]),
    .quat_x  (in_tdata[Q0 + QUAT_W +: QUAT_W]),
    .quat_y  (in_tdata[Q0 + 2*QUAT_W +: QUAT_W]),
    .quat_z  (in_tdata[Q0 + 3*QUAT_W +: QUAT_W]),
    .vld_out (rot_vld),
    .rabs    (rabs)
  );

  ebb_scale #(.COORD_WIDTH(CW)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_scl),
    .rabs    (rabs),
    .semi    (semi_dly_r[ROT_LAT-1]),
    .vld_out (scl_vld),
    .sumsq   (sumsq)
  );

  // one root pipeline per box axis
  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      ebb_isqrt #(.COORD_WIDTH(CW)) u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_sqrt),
        .rad     (sumsq[a]),
        .vld_out (sqrt_vld[a]),
        .root    (delta[a])
      );
    end
  endgenerate

  ebb_corner #(.COORD_WIDTH(CW)) u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_cnr),
    .centre  (ctr_dly_r[C_DLY-1]),
    .delta   (delta),
    .vld_out (cnr_vld),
    .corners (corners)
  );

  assign out_tvalid = cnr_vld;
  assign out_tdata  = OUT_W'(corners);
endmodule
`default_nettype wire

FILE: rtl/ebb_rot.sv
`timescale 1ns / 1ps
`default_nettype none
module ebb_rot
  import ebb_pkg::*;
(
  input  wire                                clk,
  input  wire                                rst_n,
  input  pipe_ctl_t                          ctl_in,
  input  wire signed [QUAT_W-1:0]            quat_w,
  input  wire signed [QUAT_W-1:0]            quat_x,
  input  wire signed [QUAT_W-1:0]            quat_y,
  input  wire signed [QUAT_W-1:0]            quat_z,
  output logic                               vld_out,
  output logic [8:0][QUAT_FRAC:0]            rabs
);
  localparam int PW = 2*QUAT_W - QUAT_FRAC;   // floored product width
  localparam int EW = PW + 2;                 // matrix entry width
  localparam logic signed [EW-1:0] ONE = EW'(1) <<< QUAT_FRAC;

  // products: xx yy zz xy xz yz wx wy wz
  logic signed [8:0][PW-1:0] prod_r;
  logic signed [8:0][PW-1:0] prod_nxt;
  logic [8:0][QUAT_FRAC:0]   rabs_r;
  logic [8:0][QUAT_FRAC:0]   rabs_nxt;
  logic [1:0]                vld_r;

  function automatic logic signed [PW-1:0] qmul(input logic signed [QUAT_W-1:0] a,
                                                input logic signed [QUAT_W-1:0] b);
    logic signed [2*QUAT_W-1:0] p;
    p = a * b;
    return p[2*QUAT_W-1:QUAT_FRAC];
  endfunction

  function automatic logic signed [EW-1:0] ext(input logic signed [PW-1:0] v);
    return {{2{v[PW-1]}}, v};
  endfunction

  function automatic logic [QUAT_FRAC:0] sat_abs(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] a;
    a = e[EW-1] ? -e : e;
    if (a > ONE) return ONE[QUAT_FRAC:0];
    return a[QUAT_FRAC:0];
  endfunction

  always_comb begin
    prod_nxt[0] = qmul(quat_x, quat_x);
    prod_nxt[1] = qmul(quat_y, quat_y);
    prod_nxt[2] = qmul(quat_z, quat_z);
    prod_nxt[3] = qmul(quat_x, quat_y);
    prod_nxt[4] = qmul(quat_x, quat_z);
    prod_nxt[5] = qmul(quat_y, quat_z);
    prod_nxt[6] = qmul(quat_w, quat_x);
    prod_nxt[7] = qmul(quat_w, quat_y);
    prod_nxt[8] = qmul(quat_w, quat_z);
  end

  always_comb begin
    rabs_nxt[0] = sat_abs(ONE - ((ext(prod_r[1]) + ext(prod_r[2])) <<< 1));
    rabs_nxt[1] = sat_abs((ext(prod_r[3]) - ext(prod_r[8])) <<< 1);
    rabs_nxt[2] = sat_abs((ext(prod_r[4]) + ext(prod_r[7])) <<< 1);
    rabs_nxt[3] = sat_abs((ext(prod_r[3]) + ext(prod_r[8])) <<< 1);
    rabs_nxt[4] = sat_abs(ONE - ((ext(prod_r[0]) + ext(prod_r[2])) <<< 1));
    rabs_nxt[5] = sat_abs((ext(prod_r[5]) - ext(prod_r[6])) <<< 1);
    rabs_nxt[6] = sat_abs((ext(prod_r[4]) - ext(prod_r[7])) <<< 1);
    rabs_nxt[7] = sat_abs((ext(prod_r[5]) + ext(prod_r[6])) <<< 1);
    rabs_nxt[8] = sat_abs(ONE - ((ext(prod_r[0]) + ext(prod_r[1])) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_in.en) begin
      vld_r <= {vld_r[0], ctl_in.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      prod_r <= prod_nxt;
      rabs_r <= rabs_nxt;
    end
  end

  assign vld_out = vld_r[1];
  assign rabs    = rabs_r;
endmodule
`default_nettype wire

FILE: rtl/ebb_scale.sv
`timescale 1ns / 1ps
`default_nettype none
module ebb_scale
  import ebb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  pipe_ctl_t                          ctl_in,
  input  wire  [8:0][QUAT_FRAC:0]            rabs,
  input  wire  [2:0][COORD_WIDTH-2:0]        semi,
  output logic                               vld_out,
  output logic [2:0][2*COORD_WIDTH-1:0]      sumsq
);
  localparam int SW = COORD_WIDTH - 1;

  logic [8:0][SW-1:0]              m_r;
  logic [8:0][SW-1:0]              m_nxt;
  logic [8:0][2*SW-1:0]            sq_r;
  logic [8:0][2*SW-1:0]            sq_nxt;
  logic [2:0][2*COORD_WIDTH-1:0]   sum_r;
  logic [2:0][2*COORD_WIDTH-1:0]   sum_nxt;
  logic [2:0]                      vld_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic [SW+QUAT_FRAC:0] p;
      p        = (SW+QUAT_FRAC+1)'(rabs[k]) * (SW+QUAT_FRAC+1)'(semi[k%3]);
      m_nxt[k] = p[SW+QUAT_FRAC-1:QUAT_FRAC];
      sq_nxt[k] = (2*SW)'(m_r[k]) * (2*SW)'(m_r[k]);
    end
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = (2*COORD_WIDTH)'(sq_r[3*i]) + (2*COORD_WIDTH)'(sq_r[3*i+1])
                 + (2*COORD_WIDTH)'(sq_r[3*i+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_in.en) begin
      vld_r <= {vld_r[1:0], ctl_in.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      m_r   <= m_nxt;
      sq_r  <= sq_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign vld_out = vld_r[2];
  assign sumsq   = sum_r;
endmodule
`default_nettype wire

FILE: rtl/ebb_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// one root bit per stage, restoring method
module ebb_isqrt
  import ebb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  pipe_ctl_t                    ctl_in,
  input  wire  [2*COORD_WIDTH-1:0]     rad,
  output logic                         vld_out,
  output logic [COORD_WIDTH-1:0]       root
);
  localparam int N = COORD_WIDTH;

  logic [N-1:0][N:0]     rem_r;
  logic [N-1:0][N-1:0]   root_r;
  logic [N-1:0][2*N-1:0] rad_r;
  logic [N-1:0]          vld_r;

  genvar s;
  generate
    for (s = 0; s < N; s++) begin : g_stage
      logic [N:0]     rem_in;
      logic [N-1:0]   root_in;
      logic [2*N-1:0] rad_in;
      logic           vld_in;
      logic [N+2:0]   rem_sh;
      logic [N+2:0]   trial;
      logic           ge;
      logic [N+2:0]   rem_sub;

      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad;
        assign vld_in  = ctl_in.vld;
      end else begin : g_next
        assign rem_in  = rem_r[s-1];
        assign root_in = root_r[s-1];
        assign rad_in  = rad_r[s-1];
        assign vld_in  = vld_r[s-1];
      end

      assign rem_sh  = {rem_in, rad_in[2*N-1:2*N-2]};
      assign trial   = {1'b0, root_in, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_sub = rem_sh - trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (ctl_in.en) begin
          vld_r[s] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (ctl_in.en) begin
          rem_r[s]  <= ge ? rem_sub[N:0] : rem_sh[N:0];
          root_r[s] <= {root_in[N-2:0], ge};
          rad_r[s]  <= {rad_in[2*N-3:0], 2'b00};
        end
      end
    end
  endgenerate

  assign vld_out = vld_r[N-1];
  assign root    = root_r[N-1];
endmodule
`default_nettype wire

FILE: rtl/ebb_corner.sv
`timescale 1ns / 1ps
`default_nettype none
module ebb_corner
  import ebb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  pipe_ctl_t                            ctl_in,
  input  wire  [2:0][COORD_WIDTH-1:0]          centre,
  input  wire  [2:0][COORD_WIDTH-1:0]          delta,
  output logic                                 vld_out,
  output logic [5:0][COORD_WIDTH-1:0]          corners
);
  localparam int XW = COORD_WIDTH + 2;
  localparam logic signed [XW-1:0] HI = (XW'(1) <<< (COORD_WIDTH-1)) - XW'(1);
  localparam logic signed [XW-1:0] LO = -HI - XW'(1);

  logic [5:0][COORD_WIDTH-1:0] box_r;
  logic [5:0][COORD_WIDTH-1:0] box_nxt;
  logic                        vld_r;

  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [XW-1:0] v);
    if (v > HI) return HI[COORD_WIDTH-1:0];
    if (v < LO) return LO[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [XW-1:0] c;
      logic signed [XW-1:0] d;
      c = {{2{centre[i][COORD_WIDTH-1]}}, centre[i]};
      d = {2'b00, delta[i]};
      box_nxt[i]   = sat(c - d);
      box_nxt[3+i] = sat(c + d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_in.en) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      box_r <= box_nxt;
    end
  end

  assign vld_out = vld_r;
  assign corners = box_r;
endmodule
`default_nettype wire

FILE: rtl/ebb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ebb_checker
  import ebb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire                                     clk,
  input wire                                     rst_n,
  input wire                                     in_tvalid,
  input wire                                     in_tready,
  input wire [((6*COORD_WIDTH+125+7)/8)*8-1:0]   in_tdata,
  input wire                                     out_tvalid,
  input wire                                     out_tready,
  input wire [((6*COORD_WIDTH+7)/8)*8-1:0]       out_tdata
);
  localparam int CW = COORD_WIDTH;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side only blocks while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output slot");

  // lower corner never above upper corner
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[0 +: CW])    <= $signed(out_tdata[3*CW +: CW])) &&
      ($signed(out_tdata[CW +: CW])   <= $signed(out_tdata[4*CW +: CW])) &&
      ($signed(out_tdata[2*CW +: CW]) <= $signed(out_tdata[5*CW +: CW])))
    else $error("box corners out of order");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);
endmodule

bind ellipsoid_bounding_box_unit ebb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ebb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: tb/ellipsoid_bounding_box_unit_test.sv
`timescale 1ns / 1ps
module ellipsoid_bounding_box_unit_test;
  import ebb_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int IN_W    = ((6*CW+125+7)/8)*8;
  localparam int OUT_W   = ((6*CW+7)/8)*8;
  localparam int LAT     = CW + 6;
  localparam int WD_MAX  = 2000;
  localparam logic signed [63:0] Q1 = 64'sd1 << QUAT_FRAC;

  typedef struct {
    logic signed [CW-1:0] c [3];
    logic signed [31:0]   q [4];   // w, x, y, z
    logic [CW-2:0]        s [3];
  } ellipsoid_t;

  typedef struct {
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
  } box_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  box_t box_q [$];
  int errors = 0;
  int boxes_seen = 0;
  int sent = 0;
  int idle_pct = 12;
  int wd = 0;

  ellipsoid_bounding_box_unit #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Q2.30 product floored toward minus infinity
  function automatic logic signed [63:0] qprod(logic signed [63:0] a, logic signed [63:0] b);
    return (a * b) >>> QUAT_FRAC;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp(logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = (66'sd1 <<< (CW-1)) - 1;
    mn = -mx - 1;
    if (v > mx) return mx[CW-1:0];
    if (v < mn) return mn[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic box_t predict_box(ellipsoid_t e);
    logic signed [63:0] w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz, ent;
    logic signed [63:0] rm [3][3];
    logic [127:0] acc, p, m;
    logic [63:0] d;
    box_t b;
    w = e.q[0]; x = e.q[1]; y = e.q[2]; z = e.q[3];
    xx = qprod(x, x); yy = qprod(y, y); zz = qprod(z, z);
    xy = qprod(x, y); xz = qprod(x, z); yz = qprod(y, z);
    wx = qprod(w, x); wy = qprod(w, y); wz = qprod(w, z);
    rm[0][0] = Q1 - 2*(yy+zz); rm[0][1] = 2*(xy-wz);      rm[0][2] = 2*(xz+wy);
    rm[1][0] = 2*(xy+wz);      rm[1][1] = Q1 - 2*(xx+zz); rm[1][2] = 2*(yz-wx);
    rm[2][0] = 2*(xz-wy);      rm[2][1] = 2*(yz+wx);      rm[2][2] = Q1 - 2*(xx+yy);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        ent = rm[i][j];
        if (ent > Q1) ent = Q1;
        if (ent < -Q1) ent = -Q1;
        if (ent < 0) ent = -ent;
        p = {64'd0, ent} * {97'd0, e.s[j]};
        m = p >> QUAT_FRAC;
        acc = acc + m * m;
      end
      d = int_sqrt(acc);
      b.lo[i] = clamp(66'(e.c[i]) - $signed({2'b0, d}));
      b.hi[i] = clamp(66'(e.c[i]) + $signed({2'b0, d}));
    end
    return b;
  endfunction

  // one ellipsoid per transfer; expectation queued at acceptance
  task automatic send_ellipsoid(ellipsoid_t e);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tdata <= IN_W'({e.s[2], e.s[1], e.s[0], e.q[3], e.q[2], e.q[1], e.q[0],
                       e.c[2], e.c[1], e.c[0]});
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    box_q.push_back(predict_box(e));
    sent++;
  endtask

  function automatic logic [31:0] rand_quat_part();
    case ($urandom_range(5))
      0: return 32'sd1 << 30;
      1: return -(32'sd1 << 30);
      2: return 0;
      default: return $signed($urandom_range(32'h8000_0000)) - (32'sd1 <<< 30);
    endcase
  endfunction

  function automatic logic [CW-2:0] rand_axis();
    case ($urandom_range(5))
      0: return $urandom_range(1, 2**20);
      1: return {(CW-1){1'b1}};
      2: return 0;
      default: return (CW-1)'($urandom);
    endcase
  endfunction

  // random ellipsoid; with unit_q a unit-ish quaternion from small integer direction, scaled to Q2.30
  function automatic ellipsoid_t rand_ellipsoid(bit unit_q);
    ellipsoid_t e;
    real v [4];
    real n;
    for (int i = 0; i < 3; i++) begin
      e.c[i] = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 32'h7fff_ff00 : 32'h8000_0100)
                                        : $urandom;
      e.s[i] = rand_axis();
    end
    if (unit_q) begin
      n = 0;
      for (int i = 0; i < 4; i++) begin
        v[i] = $itor($signed($urandom_range(2000))) - 1000.0;
        n += v[i] * v[i];
      end
      if (n == 0) begin v[0] = 1; n = 1; end
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) e.q[i] = $rtoi(v[i] / n * 1073741823.0);
    end else begin
      for (int i = 0; i < 4; i++) e.q[i] = rand_quat_part();
    end
    return e;
  endfunction

  task automatic test_directed();
    ellipsoid_t e;
    // identity orientation, axes at extremes, centre at range limits
    for (int k = 0; k < 12; k++) begin
      e.q[0] = (k % 2) ? -(32'sd1 << 30) : (32'sd1 << 30);
      e.q[1] = 0; e.q[2] = 0; e.q[3] = 0;
      for (int i = 0; i < 3; i++) begin
        e.c[i] = (k < 4) ? 32'h7fff_ffff : (k < 8) ? 32'h8000_0000 : 0;
        e.s[i] = (k % 3 == 0) ? {(CW-1){1'b1}} : (k % 3 == 1) ? 1 : 0;
      end
      send_ellipsoid(e);
    end
    // pure axis rotations, 90 degrees about z, and non-unit quaternions
    for (int k = 0; k < 4; k++) begin
      e = rand_ellipsoid(1);
      foreach (e.q[i]) e.q[i] = (i == k) ? (32'sd1 << 30) : 0;
      send_ellipsoid(e);
    end
    e = rand_ellipsoid(1);
    e.q[0] = 32'sd759250125; e.q[1] = 0; e.q[2] = 0; e.q[3] = 32'sd759250125;
    send_ellipsoid(e);
    foreach (e.q[i]) e.q[i] = 32'sd1 << 30;
    send_ellipsoid(e);
    foreach (e.q[i]) e.q[i] = -(32'sd1 << 30);
    send_ellipsoid(e);
    foreach (e.q[i]) e.q[i] = 0;
    send_ellipsoid(e);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_ellipsoid(rand_ellipsoid($urandom_range(9) != 0));
  endtask

  task automatic drain_boxes();
    in_tvalid <= 0;
    while (box_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_back_to_back(int n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 12;
  endtask

  // sink stalls; a quiet stretch while idle_pct is zero
  always @(posedge clk) begin
    out_tready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    box_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 3; i++) begin
        got.lo[i] = out_tdata[i*CW +: CW];
        got.hi[i] = out_tdata[(3+i)*CW +: CW];
      end
      if (box_q.size() == 0) begin
        $display("%t box with nothing expected: %h", $realtime, out_tdata);
        errors++;
      end else begin
        want = box_q.pop_front();
        boxes_seen++;
        for (int i = 0; i < 3; i++) begin
          if (got.lo[i] !== want.lo[i]) begin
            $display("%t min[%0d] expected %h actual %h", $realtime, i, want.lo[i], got.lo[i]);
            errors++;
          end
          if (got.hi[i] !== want.hi[i]) begin
            $display("%t max[%0d] expected %h actual %h", $realtime, i, want.hi[i], got.hi[i]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd <= 0;
    else if (rst_n) wd <= wd + 1;
    if (wd >= WD_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(600);
    drain_boxes();
    test_back_to_back(300);
    test_random(630);
    drain_boxes();
    repeat (LAT + 10) @(posedge clk);
    $display("sent %0d ellipsoids (directed extremes, rotations, random), checked %0d boxes",
             sent, boxes_seen);
    if (errors == 0 && box_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
